// File: src/fsau_pkg.sv
package fsau_pkg;

    localparam int STACK_DEPTH_DEF  = 64;
    localparam int RETURN_DEPTH_DEF = 32;
    localparam int DICT_BYTES_DEF   = 1024;

    localparam int OP_W   = 7;
    localparam int CELL_W = 16;

    localparam logic [OP_W-1:0] OP_DROP   = 7'd0;
    localparam logic [OP_W-1:0] OP_DUP    = 7'd1;
    localparam logic [OP_W-1:0] OP_SWAP   = 7'd2;
    localparam logic [OP_W-1:0] OP_OVER   = 7'd3;
    localparam logic [OP_W-1:0] OP_ROT    = 7'd4;
    localparam logic [OP_W-1:0] OP_ADD    = 7'd5;
    localparam logic [OP_W-1:0] OP_SUB    = 7'd6;
    localparam logic [OP_W-1:0] OP_MUL    = 7'd7;
    localparam logic [OP_W-1:0] OP_DIV    = 7'd8;
    localparam logic [OP_W-1:0] OP_MOD    = 7'd9;
    localparam logic [OP_W-1:0] OP_NEG    = 7'd10;
    localparam logic [OP_W-1:0] OP_AND    = 7'd11;
    localparam logic [OP_W-1:0] OP_OR     = 7'd12;
    localparam logic [OP_W-1:0] OP_XOR    = 7'd13;
    localparam logic [OP_W-1:0] OP_NOT    = 7'd14;
    localparam logic [OP_W-1:0] OP_LSH    = 7'd15;
    localparam logic [OP_W-1:0] OP_RSH    = 7'd16;
    localparam logic [OP_W-1:0] OP_EQ     = 7'd17;
    localparam logic [OP_W-1:0] OP_LT     = 7'd18;
    localparam logic [OP_W-1:0] OP_GT     = 7'd19;
    localparam logic [OP_W-1:0] OP_NE     = 7'd20;
    localparam logic [OP_W-1:0] OP_FETCH  = 7'd21;
    localparam logic [OP_W-1:0] OP_STORE  = 7'd22;
    localparam logic [OP_W-1:0] OP_CFETCH = 7'd23;
    localparam logic [OP_W-1:0] OP_CSTORE = 7'd24;
    localparam logic [OP_W-1:0] OP_TOR    = 7'd30;
    localparam logic [OP_W-1:0] OP_RFROM  = 7'd31;
    localparam logic [OP_W-1:0] OP_CELLS  = 7'd34;
    localparam logic [OP_W-1:0] OP_DADD   = 7'd41;
    localparam logic [OP_W-1:0] OP_DSUB   = 7'd42;
    localparam logic [OP_W-1:0] OP_DNEG   = 7'd43;
    localparam logic [OP_W-1:0] OP_ABS    = 7'd44;
    localparam logic [OP_W-1:0] OP_MAX    = 7'd47;
    localparam logic [OP_W-1:0] OP_MIN    = 7'd48;
    localparam logic [OP_W-1:0] OP_IDX    = 7'd60;
    localparam logic [OP_W-1:0] OP_FOR    = 7'd61;
    localparam logic [OP_W-1:0] OP_LIT    = 7'd64;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_POP, S_CAP, S_RRD, S_RCAP, S_DRD, S_DCAP, S_EXEC,
        S_DIV, S_DWR, S_RPUSH, S_PUSH, S_ORD, S_OCAP
    } t_state;

    typedef struct packed {
        logic [2:0] npop;
        logic [1:0] npush;
        logic       rpop;
        logic       rpeek;
        logic       rpush;
        logic [1:0] nrd;
        logic [1:0] nwr;
        logic       is_div;
    } t_ctl;

    function automatic t_ctl decode(input logic [OP_W-1:0] op);
        t_ctl c;
        c = '0;
        case (op)
            OP_DROP: c.npop = 3'd1;
            OP_DUP: begin
                c.npop = 3'd1; c.npush = 2'd2;
            end
            OP_SWAP: begin
                c.npop = 3'd2; c.npush = 2'd2;
            end
            OP_OVER: begin
                c.npop = 3'd2; c.npush = 2'd3;
            end
            OP_ROT: begin
                c.npop = 3'd3; c.npush = 2'd3;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_LSH, OP_RSH,
            OP_EQ, OP_LT, OP_GT, OP_NE, OP_MAX, OP_MIN: begin
                c.npop = 3'd2; c.npush = 2'd1;
            end
            OP_DIV, OP_MOD: begin
                c.npop = 3'd2; c.npush = 2'd1; c.is_div = 1'b1;
            end
            OP_NEG, OP_NOT, OP_ABS, OP_CELLS: begin
                c.npop = 3'd1; c.npush = 2'd1;
            end
            OP_FETCH: begin
                c.npop = 3'd1; c.npush = 2'd1; c.nrd = 2'd2;
            end
            OP_CFETCH: begin
                c.npop = 3'd1; c.npush = 2'd1; c.nrd = 2'd1;
            end
            OP_STORE: begin
                c.npop = 3'd2; c.nwr = 2'd2;
            end
            OP_CSTORE: begin
                c.npop = 3'd2; c.nwr = 2'd1;
            end
            OP_TOR, OP_FOR: begin
                c.npop = 3'd1; c.rpush = 1'b1;
            end
            OP_RFROM: begin
                c.rpop = 1'b1; c.npush = 2'd1;
            end
            OP_IDX: begin
                c.rpeek = 1'b1; c.npush = 2'd1;
            end
            OP_DADD, OP_DSUB: begin
                c.npop = 3'd4; c.npush = 2'd2;
            end
            OP_DNEG: begin
                c.npop = 3'd2; c.npush = 2'd2;
            end
            OP_LIT: c.npush = 2'd1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: src/fsau_div.sv
module fsau_div import fsau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CELL_W-1:0] i_dividend,
    input  logic [CELL_W-1:0] i_divisor,
    output logic              o_done,
    output logic [CELL_W-1:0] o_quo,
    output logic [CELL_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_cnt;
    logic [CELL_W-1:0] r_rem;
    logic [CELL_W-1:0] r_quo;
    logic [CELL_W-1:0] r_den;
    logic              r_negq;
    logic              r_negr;
    logic [CELL_W:0]   rem_sh;
    logic [CELL_W:0]   diff;

    // One restoring step per cycle on the magnitudes.
    assign rem_sh = {r_rem, r_quo[CELL_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 4'd15) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= 4'd0;
            r_rem  <= '0;
            r_quo  <= i_dividend[CELL_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_den  <= i_divisor[CELL_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_negq <= i_dividend[CELL_W-1] ^ i_divisor[CELL_W-1];
            r_negr <= i_dividend[CELL_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (!diff[CELL_W]) begin
                r_rem <= diff[CELL_W-1:0];
                r_quo <= {r_quo[CELL_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[CELL_W-1:0];
                r_quo <= {r_quo[CELL_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_negq ? (~r_quo + 1'b1) : r_quo;
    assign o_rem  = r_negr ? (~r_rem + 1'b1) : r_rem;

endmodule

// File: src/fsau_alu.sv
module fsau_alu import fsau_pkg::*; (
    input  logic [OP_W-1:0]   i_op,
    input  logic [CELL_W-1:0] i_o0,
    input  logic [CELL_W-1:0] i_o1,
    input  logic [CELL_W-1:0] i_o2,
    input  logic [CELL_W-1:0] i_o3,
    input  logic [CELL_W-1:0] i_lit,
    input  logic [CELL_W-1:0] i_rval,
    input  logic [7:0]        i_byte0,
    input  logic [7:0]        i_byte1,
    input  logic [CELL_W-1:0] i_quo,
    input  logic [CELL_W-1:0] i_rem,
    output logic [CELL_W-1:0] o_res0,
    output logic [CELL_W-1:0] o_res1,
    output logic [CELL_W-1:0] o_res2
);

    logic [2*CELL_W-1:0] prod;
    logic [2*CELL_W-1:0] dsum;
    logic [2*CELL_W-1:0] dx;
    logic [2*CELL_W-1:0] dy;
    logic [3:0]          rsh;

    assign prod = i_o1 * i_o0;
    assign dx   = {i_o2, i_o3};
    assign dy   = {i_o0, i_o1};
    assign rsh  = (i_o0 > 16'd15) ? 4'd15 : i_o0[3:0];

    always_comb begin
        case (i_op)
            OP_DADD: dsum = dx + dy;
            OP_DSUB: dsum = dx - dy;
            default: dsum = '0 - dy;
        endcase
    end

    // Operand 0 is the first value popped, i.e. the old top of stack.
    always_comb begin
        o_res0 = '0;
        o_res1 = '0;
        o_res2 = '0;
        case (i_op)
            OP_DUP: begin
                o_res0 = i_o0; o_res1 = i_o0;
            end
            OP_SWAP: begin
                o_res0 = i_o0; o_res1 = i_o1;
            end
            OP_OVER: begin
                o_res0 = i_o1; o_res1 = i_o0; o_res2 = i_o1;
            end
            OP_ROT: begin
                o_res0 = i_o1; o_res1 = i_o0; o_res2 = i_o2;
            end
            OP_ADD:    o_res0 = i_o1 + i_o0;
            OP_SUB:    o_res0 = i_o1 - i_o0;
            OP_MUL:    o_res0 = prod[CELL_W-1:0];
            OP_DIV:    o_res0 = (i_o0 == '0) ? '0 : i_quo;
            OP_MOD:    o_res0 = (i_o0 == '0) ? '0 : i_rem;
            OP_NEG:    o_res0 = ~i_o0 + 1'b1;
            OP_AND:    o_res0 = i_o1 & i_o0;
            OP_OR:     o_res0 = i_o1 | i_o0;
            OP_XOR:    o_res0 = i_o1 ^ i_o0;
            OP_NOT:    o_res0 = ~i_o0;
            OP_LSH:    o_res0 = (i_o0 > 16'd15) ? '0 : (i_o1 << i_o0[3:0]);
            OP_RSH:    o_res0 = CELL_W'($signed(i_o1) >>> rsh);
            OP_EQ:     o_res0 = CELL_W'(i_o1 == i_o0);
            OP_LT:     o_res0 = CELL_W'($signed(i_o1) < $signed(i_o0));
            OP_GT:     o_res0 = CELL_W'($signed(i_o1) > $signed(i_o0));
            OP_NE:     o_res0 = CELL_W'(i_o1 != i_o0);
            OP_FETCH:  o_res0 = {i_byte1, i_byte0};
            OP_CFETCH: o_res0 = {8'd0, i_byte0};
            OP_RFROM, OP_IDX: o_res0 = i_rval;
            OP_CELLS:  o_res0 = {i_o0[CELL_W-2:0], 1'b0};
            OP_DADD, OP_DSUB, OP_DNEG: begin
                o_res0 = dsum[CELL_W-1:0]; o_res1 = dsum[2*CELL_W-1:CELL_W];
            end
            OP_ABS:    o_res0 = i_o0[CELL_W-1] ? (~i_o0 + 1'b1) : i_o0;
            OP_MAX:    o_res0 = ($signed(i_o0) > $signed(i_o1)) ? i_o0 : i_o1;
            OP_MIN:    o_res0 = ($signed(i_o0) < $signed(i_o1)) ? i_o0 : i_o1;
            OP_LIT:    o_res0 = i_lit;
            default: begin
                o_res0 = '0;
            end
        endcase
    end

endmodule

// File: src/forth_stack_alu_unit.sv
// Forth primitive unit: each input transfer carries one opcode (and a literal
// for a push), each output transfer reports the top two stack cells, both
// stack depths and a status code for that primitive. Exactly one output
// transfer follows every input transfer, in order.
// Steps, in order: the idle step in which the item is taken, a read and a
// capture step per popped cell, a read and a capture step for a return stack
// read, a read and a capture step per dictionary byte read, the execute step,
// the divide for / and MOD with a nonzero divisor, then a write step per byte
// written, a return stack push or a push step per cell pushed, and last a
// read-back and a register step for the result. All of this runs on one
// sequencer with a single-port dictionary memory, so the input is stalled
// from acceptance until the result is registered.
// A registered result stays on the output while the receiver stalls; the next
// item may be taken meanwhile, and the sequencer waits at its last step until
// the output register is free.
// Reset empties both stacks; stack and dictionary contents are not cleared
// and the dictionary must be written before it is read. DICT_BYTES must be a
// power of two, addresses wrap modulo its size.
module forth_stack_alu_unit import fsau_pkg::*; #(
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int RETURN_DEPTH = RETURN_DEPTH_DEF,
    parameter int DICT_BYTES   = DICT_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [CELL_W-1:0] i_literal,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [CELL_W-1:0] o_top,
    output logic signed [CELL_W-1:0] o_next,
    output logic [6:0]               o_depth,
    output logic [5:0]               o_return_depth,
    output logic [1:0]               o_status
);

    localparam int DAW = $clog2(STACK_DEPTH);
    localparam int DCW = $clog2(STACK_DEPTH + 1);
    localparam int RAW = $clog2(RETURN_DEPTH);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);
    localparam int MAW = $clog2(DICT_BYTES);

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [CELL_W-1:0] r_lit;
    t_ctl              r_ctl;
    logic [1:0]        r_idx, n_idx;
    logic [CELL_W-1:0] r_opnd [4];
    logic [CELL_W-1:0] r_rval, n_rval;
    logic [7:0]        r_byte [2];
    logic [CELL_W-1:0] r_res [3];
    logic [DCW-1:0]    r_dcnt, n_dcnt;
    logic [RCW-1:0]    r_rcnt, n_rcnt;
    logic [1:0]        r_fault, n_fault;

    logic [CELL_W-1:0] r_dmem [STACK_DEPTH];
    logic [CELL_W-1:0] r_rmem [RETURN_DEPTH];
    logic [7:0]        r_mmem [DICT_BYTES];
    logic [CELL_W-1:0] r_da_q, r_db_q, r_r_q;
    logic [7:0]        r_m_q;
    logic [DAW-1:0]    da_addr, db_addr;
    logic              d_we, r_we, m_we;
    logic [CELL_W-1:0] m_addr_full;
    logic [7:0]        m_wdata;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_top, r_next;
    logic [6:0]        r_depth;
    logic [5:0]        r_rdepth;
    logic [1:0]        r_status;

    logic              in_take, out_free, div_start, div_done;
    logic              cap_opnd, cap_byte, cap_res;
    logic [CELL_W-1:0] quo, rem, res0, res1, res2;
    t_ctl              in_ctl;

    assign in_ctl   = decode(i_operation);
    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    fsau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_opnd[1]),
        .i_divisor  (r_opnd[0]),
        .o_done     (div_done),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    fsau_alu u_alu (
        .i_op    (r_op),
        .i_o0    (r_opnd[0]),
        .i_o1    (r_opnd[1]),
        .i_o2    (r_opnd[2]),
        .i_o3    (r_opnd[3]),
        .i_lit   (r_lit),
        .i_rval  (r_rval),
        .i_byte0 (r_byte[0]),
        .i_byte1 (r_byte[1]),
        .i_quo   (quo),
        .i_rem   (rem),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_res2  (res2)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (in_ctl.npop != 3'd0) begin
                        n_state = S_POP;
                    end else if (in_ctl.rpop || in_ctl.rpeek) begin
                        n_state = S_RRD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_POP: n_state = S_CAP;
            S_CAP: begin
                if ({1'b0, r_idx} != r_ctl.npop - 3'd1) begin
                    n_state = S_POP;
                end else if (r_ctl.nrd != 2'd0) begin
                    n_state = S_DRD;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_RRD:  n_state = S_RCAP;
            S_RCAP: n_state = S_EXEC;
            S_DRD:  n_state = S_DCAP;
            S_DCAP: n_state = (r_idx == r_ctl.nrd - 2'd1) ? S_EXEC : S_DRD;
            S_EXEC: begin
                if (r_ctl.is_div && r_opnd[0] != '0) begin
                    n_state = S_DIV;
                end else if (r_ctl.nwr != 2'd0) begin
                    n_state = S_DWR;
                end else if (r_ctl.rpush) begin
                    n_state = S_RPUSH;
                end else if (r_ctl.npush != 2'd0) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_ORD;
                end
            end
            S_DIV:   n_state = div_done ? S_PUSH : S_DIV;
            S_DWR:   n_state = (r_idx == r_ctl.nwr - 2'd1) ? S_ORD : S_DWR;
            S_RPUSH: n_state = S_ORD;
            S_PUSH:  n_state = (r_idx == r_ctl.npush - 2'd1) ? S_ORD : S_PUSH;
            S_ORD:   n_state = S_OCAP;
            S_OCAP:  n_state = out_free ? S_IDLE : S_OCAP;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath controls and next values.
    always_comb begin
        n_idx       = r_idx;
        n_rval      = r_rval;
        n_dcnt      = r_dcnt;
        n_rcnt      = r_rcnt;
        n_fault     = r_fault;
        da_addr     = DAW'(r_dcnt - 1'b1);
        db_addr     = DAW'(r_dcnt - 2'd2);
        d_we        = 1'b0;
        r_we        = 1'b0;
        m_we        = 1'b0;
        m_addr_full = r_opnd[0] + CELL_W'(r_idx);
        m_wdata     = (r_idx == 2'd0) ? r_opnd[1][7:0] : r_opnd[1][15:8];
        div_start   = 1'b0;
        cap_opnd    = 1'b0;
        cap_byte    = 1'b0;
        cap_res     = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_idx = 2'd0;
                if (in_take) begin
                    n_fault = ST_OK;
                end
            end
            S_CAP: begin
                cap_opnd = 1'b1;
                if (r_dcnt != '0) begin
                    n_dcnt = r_dcnt - 1'b1;
                end else if (n_fault == ST_OK) begin
                    n_fault = ST_UNDER;
                end
                n_idx = ({1'b0, r_idx} == r_ctl.npop - 3'd1) ? 2'd0 : r_idx + 2'd1;
            end
            S_RCAP: begin
                if (r_rcnt != '0) begin
                    n_rval = r_r_q;
                    if (r_ctl.rpop) begin
                        n_rcnt = r_rcnt - 1'b1;
                    end
                end else begin
                    n_rval = '0;
                    if (r_fault == ST_OK) begin
                        n_fault = ST_UNDER;
                    end
                end
            end
            S_DCAP: begin
                cap_byte = 1'b1;
                n_idx    = (r_idx == r_ctl.nrd - 2'd1) ? 2'd0 : r_idx + 2'd1;
            end
            S_EXEC: begin
                cap_res = 1'b1;
                if (r_ctl.is_div) begin
                    if (r_opnd[0] != '0) begin
                        div_start = 1'b1;
                    end else if (r_fault == ST_OK) begin
                        n_fault = ST_DIVZ;
                    end
                end
            end
            S_DIV: begin
                cap_res = div_done;
            end
            S_DWR: begin
                m_we  = 1'b1;
                n_idx = (r_idx == r_ctl.nwr - 2'd1) ? 2'd0 : r_idx + 2'd1;
            end
            S_RPUSH: begin
                if (r_rcnt >= RCW'(RETURN_DEPTH)) begin
                    if (r_fault == ST_OK) begin
                        n_fault = ST_OVER;
                    end
                end else begin
                    r_we   = 1'b1;
                    n_rcnt = r_rcnt + 1'b1;
                end
            end
            S_PUSH: begin
                if (r_dcnt >= DCW'(STACK_DEPTH)) begin
                    if (r_fault == ST_OK) begin
                        n_fault = ST_OVER;
                    end
                end else begin
                    d_we   = 1'b1;
                    n_dcnt = r_dcnt + 1'b1;
                end
                n_idx = (r_idx == r_ctl.npush - 2'd1) ? 2'd0 : r_idx + 2'd1;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 2'd0;
            r_dcnt      <= '0;
            r_rcnt      <= '0;
            r_fault     <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dcnt  <= n_dcnt;
            r_rcnt  <= n_rcnt;
            r_fault <= n_fault;
            if (r_state == S_OCAP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rval <= n_rval;
        if (in_take) begin
            r_op  <= i_operation;
            r_lit <= i_literal;
            r_ctl <= in_ctl;
        end
        if (cap_opnd) begin
            r_opnd[r_idx] <= (r_dcnt != '0) ? r_da_q : '0;
        end
        if (cap_byte) begin
            r_byte[r_idx[0]] <= r_m_q;
        end
        if (cap_res) begin
            r_res[0] <= res0;
            r_res[1] <= res1;
            r_res[2] <= res2;
        end
        if (r_state == S_OCAP && out_free) begin
            r_top    <= (r_dcnt >= DCW'(1)) ? r_da_q : '0;
            r_next   <= (r_dcnt >= DCW'(2)) ? r_db_q : '0;
            r_depth  <= 7'(r_dcnt);
            r_rdepth <= 6'(r_rcnt);
            r_status <= r_fault;
        end
    end

    // Data stack: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dmem[DAW'(r_dcnt)] <= r_res[r_idx];
        end
        r_da_q <= r_dmem[da_addr];
        r_db_q <= r_dmem[db_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_rmem[RAW'(r_rcnt)] <= r_opnd[0];
        end
        r_r_q <= r_rmem[RAW'(r_rcnt - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mmem[m_addr_full[MAW-1:0]] <= m_wdata;
        end
        r_m_q <= r_mmem[m_addr_full[MAW-1:0]];
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_top          = r_top;
    assign o_next         = r_next;
    assign o_depth        = r_depth;
    assign o_return_depth = r_rdepth;
    assign o_status       = r_status;

endmodule

// File: src/fsau_checker.sv
module fsau_checker import fsau_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [CELL_W-1:0] o_top,
    input logic signed [CELL_W-1:0] o_next,
    input logic [6:0]               o_depth,
    input logic [5:0]               o_return_depth
);

    // An empty stack reports zeros in both cells.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth == 7'd0 |-> o_top == '0 && o_next == '0)
        else $error("empty stack shows nonzero cells");

    a_single_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth == 7'd1 |-> o_next == '0)
        else $error("second cell nonzero with one element");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_depth <= 7'(STACK_DEPTH_DEF)
                     && o_return_depth <= 6'(RETURN_DEPTH_DEF))
        else $error("stack depth beyond capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_top)
                                      && $stable(o_depth))
        else $error("stalled result changed");

    // An input transfer always closes the input for at least the next cycle.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a transfer");

endmodule

bind forth_stack_alu_unit fsau_checker u_fsau_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_top          (o_top),
    .o_next         (o_next),
    .o_depth        (o_depth),
    .o_return_depth (o_return_depth)
);
